// File: hw/rtl/ordered_list_store_unit_defines.svh
// ============================================================================
// Ordered list store unit: assertion macros
// Shared concurrent assertion forms for the checker of the list store.
// ============================================================================
`ifndef ORDERED_LIST_STORE_UNIT_DEFINES_SVH
`define ORDERED_LIST_STORE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OLSU_ASSERT_NOW(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OLSU_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/olsu_pkg.sv
// ============================================================================
// Ordered list store unit: package
// Item and result types, command, status and state codes, and store control.
// ============================================================================
package olsu_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 6;

  typedef enum logic [1:0] {
    CMD_INSERT_FRONT = 2'd0,
    CMD_APPEND_BACK  = 2'd1,
    CMD_DELETE       = 2'd2,
    CMD_READ_ALL     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_DONE    = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_BAD_POS = 3'd2,
    STAT_ELEMENT = 3'd3,
    STAT_END     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DUMP,
    ST_DUMP_END
  } state_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         position;
  } item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] element;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } res_t;

  typedef struct packed {
    logic             wr_en;
    logic             wr_front;
    logic [CNT_W-1:0] wr_idx;
    logic             rd_en;
    logic [CNT_W-1:0] rd_idx;
  } store_ctl_t;

endpackage

// File: hw/rtl/olsu_store.sv
// ============================================================================
// Ordered list store unit: element store
// Ring buffer memory addressed by position from the front of the list.
// ============================================================================
module olsu_store import olsu_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  store_ctl_t               ctl_i,
  input  logic signed [DATA_W-1:0] wr_data_i,
  output logic signed [DATA_W-1:0] rd_data_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned PHY_W = IDX_W + 1;

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rd_data_q;
  logic [IDX_W-1:0]         head_q, head_d;
  logic [IDX_W-1:0]         head_dec;
  logic [PHY_W-1:0]         wr_sum, rd_sum;
  logic [IDX_W-1:0]         wr_phys, rd_phys, wr_addr;

  assign head_dec = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - IDX_W'(1);

  always_comb begin
    wr_sum = {1'b0, head_q} + {1'b0, ctl_i.wr_idx[IDX_W-1:0]};
    if (wr_sum >= PHY_W'(CAPACITY)) begin
      wr_sum = wr_sum - PHY_W'(CAPACITY);
    end
    rd_sum = {1'b0, head_q} + {1'b0, ctl_i.rd_idx[IDX_W-1:0]};
    if (rd_sum >= PHY_W'(CAPACITY)) begin
      rd_sum = rd_sum - PHY_W'(CAPACITY);
    end
    wr_phys = wr_sum[IDX_W-1:0];
    rd_phys = rd_sum[IDX_W-1:0];
    wr_addr = ctl_i.wr_front ? head_dec : wr_phys;
    head_d  = (ctl_i.wr_en && ctl_i.wr_front) ? head_dec : head_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_phys];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/ordered_list_store_unit.sv
// ============================================================================
// Ordered list store unit
// Bounded ordered list of signed 32-bit values with front insert, back
// append, delete at position and full read-out.
// ============================================================================
// An item is taken when start is high and busy is low, and its results come
// out on res_o, one per cycle while res_strobe_o is high, with no way to hold
// them back. Insert, append, a delete of the last element, a read-out of an
// empty list and every rejected command keep busy low and give their single
// result on the cycle after the item is taken. A delete at position p of a
// list of n elements keeps busy high while every element behind the deleted
// one is moved by one read and one write through the single memory port
// pair; its result comes out in the first cycle that busy is low again. A
// read-out of n elements, n at least one, gives n element results while busy
// is high and then an end marker, on consecutive cycles, one memory read per
// element, each read passing the store's read register and the result
// register; the end marker comes out in the first cycle that busy is low.
module ordered_list_store_unit import olsu_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  item_t item_i,
  output logic  res_strobe_o,
  output res_t  res_o
);

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         len_q, len_d;
  logic [CNT_W-1:0]         idx_q, idx_d;
  logic                     res_valid_q, res_valid_d;
  res_t                     res_q, res_d;
  store_ctl_t               ctl;
  logic signed [DATA_W-1:0] wr_data;
  logic signed [DATA_W-1:0] rd_data;
  logic                     accept;
  logic                     pos_ok;
  logic                     is_full;
  logic                     shift_last;
  logic                     dump_last;

  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign pos_ok     = (item_i.position != '0) && (item_i.position <= len_q);
  assign is_full    = (len_q >= CNT_W'(CAPACITY));
  assign shift_last = ((idx_q + CNT_W'(1)) == (len_q - CNT_W'(1)));
  assign dump_last  = ((idx_q + CNT_W'(1)) == len_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && item_i.cmd == CMD_DELETE && pos_ok && item_i.position != len_q) begin
          state_d = ST_SHIFT_RD;
        end else if (accept && item_i.cmd == CMD_READ_ALL && len_q != '0) begin
          state_d = ST_DUMP;
        end
      end
      ST_SHIFT_RD: state_d = ST_SHIFT_WR;
      ST_SHIFT_WR: state_d = shift_last ? ST_IDLE : ST_SHIFT_RD;
      ST_DUMP:     state_d = dump_last ? ST_DUMP_END : ST_DUMP;
      ST_DUMP_END: state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    len_d       = len_q;
    idx_d       = idx_q;
    ctl         = '0;
    wr_data     = item_i.value;
    res_valid_d = 1'b0;
    res_d       = '{status: STAT_DONE, element: '0, count: len_q, last: 1'b1};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          unique case (item_i.cmd)
            CMD_INSERT_FRONT, CMD_APPEND_BACK: begin
              if (is_full) begin
                res_d.status = STAT_FULL;
              end else begin
                ctl.wr_en    = 1'b1;
                ctl.wr_front = (item_i.cmd == CMD_INSERT_FRONT);
                ctl.wr_idx   = len_q;
                len_d        = len_q + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              if (!pos_ok) begin
                res_d.status = STAT_BAD_POS;
              end else if (item_i.position == len_q) begin
                len_d = len_q - CNT_W'(1);
              end else begin
                res_valid_d = 1'b0;
                idx_d       = item_i.position - CNT_W'(1);
              end
            end
            CMD_READ_ALL: begin
              if (len_q == '0) begin
                res_d.status = STAT_END;
              end else begin
                res_valid_d = 1'b0;
                idx_d       = '0;
                ctl.rd_en   = 1'b1;
                ctl.rd_idx  = '0;
              end
            end
            default: res_valid_d = 1'b0;
          endcase
        end
      end
      ST_SHIFT_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_idx = idx_q + CNT_W'(1);
      end
      ST_SHIFT_WR: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_idx = idx_q;
        wr_data    = rd_data;
        idx_d      = idx_q + CNT_W'(1);
        if (shift_last) begin
          len_d       = len_q - CNT_W'(1);
          res_valid_d = 1'b1;
        end
      end
      ST_DUMP: begin
        res_valid_d   = 1'b1;
        res_d.status  = STAT_ELEMENT;
        res_d.element = rd_data;
        res_d.last    = 1'b0;
        if (!dump_last) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_idx = idx_q + CNT_W'(1);
          idx_d      = idx_q + CNT_W'(1);
        end
      end
      ST_DUMP_END: begin
        res_valid_d  = 1'b1;
        res_d.status = STAT_END;
      end
      default: res_valid_d = 1'b0;
    endcase
    res_d.count = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    res_q <= res_d;
  end

  olsu_store #(
    .CAPACITY(CAPACITY)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

  assign res_strobe_o = res_valid_q;
  assign res_o        = res_q;

endmodule

// File: hw/rtl/olsu_checker.sv
// ============================================================================
// Ordered list store unit: port checker
// Watches the ports of the list store for ordering and count consistency.
// ============================================================================
`include "ordered_list_store_unit_defines.svh"

module olsu_checker import olsu_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  start,
  input logic  busy,
  input item_t item_i,
  input logic  res_strobe_o,
  input res_t  res_o
);

  logic ins_take;
  logic res_last;
  logic elem_res;
  logic elem_or_end;
  logic full_res;
  logic full_ok;
  logic mid_res;
  logic mid_ok;

  assign ins_take    = start && !busy &&
                       (item_i.cmd == CMD_INSERT_FRONT || item_i.cmd == CMD_APPEND_BACK);
  assign res_last    = res_strobe_o && res_o.last;
  assign elem_res    = res_strobe_o && res_o.status == STAT_ELEMENT;
  assign elem_or_end = res_strobe_o &&
                       (res_o.status == STAT_ELEMENT || res_o.status == STAT_END);
  assign full_res    = res_strobe_o && res_o.status == STAT_FULL;
  assign full_ok     = res_o.count == CNT_W'(CAPACITY) && res_o.last;
  assign mid_res     = res_strobe_o && !res_o.last;
  assign mid_ok      = busy && res_o.status == STAT_ELEMENT;

  `OLSU_ASSERT_NEXT(a_insert_answers, clk_i, rst_ni, ins_take, res_last, "Insert gave no result.")
  `OLSU_ASSERT_NEXT(a_element_follows, clk_i, rst_ni, elem_res, elem_or_end, "Read-out broke off.")
  `OLSU_ASSERT_NEXT(a_dump_count, clk_i, rst_ni, elem_res, $stable(res_o.count), "Count changed.")
  `OLSU_ASSERT_NOW(a_full_count, clk_i, rst_ni, full_res, full_ok, "Full below capacity.")
  `OLSU_ASSERT_NOW(a_element_busy, clk_i, rst_ni, mid_res, mid_ok, "Non-final result while idle.")

endmodule

bind ordered_list_store_unit olsu_checker #(.CAPACITY(CAPACITY)) u_olsu_checker (.*);
